### src/fade_gain_channel_mixer_unit_assert.svh
// Assertion macros for the fade/gain mixer RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef FADE_GAIN_CHANNEL_MIXER_UNIT_ASSERT_SVH
`define FADE_GAIN_CHANNEL_MIXER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FGCM_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FGCM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fgcm_pkg.sv
// Shared types and constants for the fade/gain channel mixer.
// No dependencies.
`default_nettype none
package fgcm_pkg;

  localparam int GAIN_W    = 20;  // Q4.16 gain
  localparam int FACTOR_W  = 18;  // Q2.16 fade factor
  localparam int CHAN_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TARGET  = 3'd4;

  localparam logic [CHAN_W-1:0]   CHAN_MONO   = 2'd1;
  localparam logic [CHAN_W-1:0]   CHAN_STEREO = 2'd2;
  localparam logic [GAIN_W-1:0]   GAIN_UNITY  = 20'd65536;
  localparam logic [GAIN_W-1:0]   GAIN_MAX    = 20'hFFFFF;
  localparam logic [FACTOR_W-1:0] FACTOR_UNITY = 18'd65536;

  // per-item control passed from front to back
  typedef struct packed {
    logic              in_mono;
    logic              out_mono;
    logic              fade_done;
    logic [GAIN_W-1:0] gain_now;
  } fgcm_ctl_t;

  localparam int CTL_W = $bits(fgcm_ctl_t);

endpackage
`default_nettype wire

### src/fade_gain_channel_mixer_unit.sv
// Top level of the fade/gain channel mixer: front end, queue, back end.
// Depends on fgcm_pkg, fgcm_front, fgcm_queue, fgcm_back.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_tvalid/in_tready   | in_tdata: left_in, right_in
//  out     | out_tvalid/out_tready | out_tdata: left_out, right_out, gain_now,
//          |                       |            fade_done
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item per cycle sustained while out_tready holds high; the gain/fade update
// (20x18 multiply) closes in the front end in the cycle the item is accepted.
// An accepted item reaches out_tvalid through the queue write, the product
// stage and the output register, in that order.
// Reset clears the queue and pipeline valids and loads the register defaults.
// A stalled output fills the back end first, then the 4-entry queue, then
// in_tready drops; cfg_ready is always high.
`default_nettype none
module fade_gain_channel_mixer_unit import fgcm_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [left_in, right_in] from bit 0, zero padded to bytes
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [left_out, right_out, gain_now, fade_done] from bit 0, zero padded to bytes
  output logic [((2*SAMPLE_BITS+GAIN_W+1+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W = ((2*SAMPLE_BITS+GAIN_W+1+7)/8)*8;
  localparam int Q_W   = CTL_W + GAIN_W + 2*SAMPLE_BITS;

  logic                   push_valid, push_ready;
  logic [SAMPLE_BITS-1:0] push_left, push_right;
  logic [GAIN_W-1:0]      push_gain;
  fgcm_ctl_t              push_ctl;
  logic                   pop_valid, pop_ready;
  logic [Q_W-1:0]         pop_data;
  fgcm_ctl_t              pop_ctl;
  logic [SAMPLE_BITS-1:0] out_left, out_right;
  logic [GAIN_W-1:0]      out_gain;
  logic                   out_done;

  assign cfg_ready = 1'b1;
  assign in_tready = push_ready;

  fgcm_front #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_left    (in_tdata[SAMPLE_BITS-1:0]),
    .in_right   (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_left  (push_left),
    .push_right (push_right),
    .push_gain  (push_gain),
    .push_ctl   (push_ctl)
  );

  fgcm_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  ({push_ctl, push_gain, push_right, push_left}),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  assign pop_ctl = pop_data[Q_W-1 -: CTL_W];

  fgcm_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_left    (pop_data[SAMPLE_BITS-1:0]),
    .q_right   (pop_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .q_gain    (pop_data[2*SAMPLE_BITS+GAIN_W-1:2*SAMPLE_BITS]),
    .q_ctl     (pop_ctl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (out_left),
    .out_right (out_right),
    .out_gain  (out_gain),
    .out_done  (out_done)
  );

  assign out_tdata = OUT_W'({out_done, out_gain, out_right, out_left});

endmodule
`default_nettype wire

### src/fgcm_front.sv
// Front end: configuration registers, gain/fade state, item classification.
// Depends on fgcm_pkg.
`default_nettype none
module fgcm_front import fgcm_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DAT_W-1:0]   cfg_data,
  input  wire logic                   in_valid,
  input  wire logic [SAMPLE_BITS-1:0] in_left,
  input  wire logic [SAMPLE_BITS-1:0] in_right,
  input  wire logic                   push_ready,
  output logic                        push_valid,
  output logic [SAMPLE_BITS-1:0]      push_left,
  output logic [SAMPLE_BITS-1:0]      push_right,
  output logic [GAIN_W-1:0]           push_gain,
  output fgcm_ctl_t                   push_ctl
);

  localparam int ONE_W = (GAIN_FRAC_BITS + 1 > FACTOR_W) ? GAIN_FRAC_BITS + 1 : FACTOR_W;
  localparam logic [ONE_W-1:0] GAIN_ONE = ONE_W'(1) << GAIN_FRAC_BITS;
  localparam int PROD_W = GAIN_W + FACTOR_W;

  logic [CHAN_W-1:0]   in_ch_r, out_ch_r;
  logic [FACTOR_W-1:0] factor_r;
  logic [GAIN_W-1:0]   target_r;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic                armed_r, armed_nxt;

  logic                accept, start_wr;
  logic [ONE_W-1:0]    factor_ext;
  logic                f_lt, f_gt, f_unity, stop;
  logic [PROD_W-1:0]   gprod, gshift;
  logic [GAIN_W-1:0]   gsat;

  assign accept   = in_valid && push_ready;
  assign start_wr = cfg_valid && (cfg_index == REG_START_LEVEL);

  // fade step: stop test, then gain * factor
  assign factor_ext = ONE_W'(factor_r);
  assign f_lt    = factor_ext < GAIN_ONE;
  assign f_gt    = factor_ext > GAIN_ONE;
  assign f_unity = (factor_ext == GAIN_ONE);
  assign stop  = (f_lt && (gain_r <= target_r)) || (f_gt && (gain_r >= target_r));
  assign gprod = PROD_W'(gain_r) * PROD_W'(factor_r);
  assign gshift = gprod >> GAIN_FRAC_BITS;
  assign gsat  = (|gshift[PROD_W-1:GAIN_W]) ? GAIN_MAX : gshift[GAIN_W-1:0];

  always_comb begin
    gain_nxt  = gain_r;
    armed_nxt = armed_r;
    if (armed_r) begin
      if (stop) begin
        armed_nxt = 1'b0;
      end else if (!f_unity) begin
        gain_nxt = gsat;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r  <= CHAN_STEREO;
      out_ch_r <= CHAN_STEREO;
      factor_r <= FACTOR_UNITY;
      target_r <= GAIN_UNITY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IN_CHANNELS:  in_ch_r  <= cfg_data[CHAN_W-1:0];
        REG_OUT_CHANNELS: out_ch_r <= cfg_data[CHAN_W-1:0];
        REG_FADE_FACTOR:  factor_r <= cfg_data[FACTOR_W-1:0];
        REG_FADE_TARGET:  target_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // gain state: start level write reloads and re-arms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_UNITY;
      armed_r <= 1'b1;
    end else if (start_wr) begin
      gain_r  <= cfg_data[GAIN_W-1:0];
      armed_r <= 1'b1;
    end else if (accept) begin
      gain_r  <= gain_nxt;
      armed_r <= armed_nxt;
    end
  end

  // classified item into the queue
  assign push_valid = in_valid;
  assign push_left  = in_left;
  assign push_right = in_right;
  assign push_gain  = gain_r;
  assign push_ctl   = '{in_mono:   (in_ch_r == CHAN_MONO),
                        out_mono:  (out_ch_r == CHAN_MONO),
                        fade_done: !armed_nxt,
                        gain_now:  gain_nxt};

`include "fade_gain_channel_mixer_unit_assert.svh"

  // once disarmed, only a start level write re-arms
  `FGCM_CHECK_NEXT(a_disarm_sticky, !armed_r && !start_wr, !armed_r, "fade re-armed")
  // disarmed gain holds
  `FGCM_CHECK_NEXT(a_gain_hold, !armed_r && !start_wr, $stable(gain_r), "disarmed gain moved")
  // unity factor never changes gain on an item
  `FGCM_CHECK_NOW(a_unity_gain, accept && f_unity, gain_nxt == gain_r, "unity factor moved gain")
  // start write re-arms the fade
  `FGCM_CHECK_NEXT(a_start_load, start_wr, armed_r, "start write did not re-arm")

endmodule
`default_nettype wire

### src/fgcm_queue.sv
// Small register queue between front and back ends.
// Depends on nothing but its parameters.
`default_nettype none
module fgcm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data,
  input  wire logic             pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign push = push_valid && push_ready;
  assign pop  = pop_ready && pop_valid;
  assign pop_data = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/fgcm_back.sv
// Back end: sample gain multiply, saturation, channel remap, output register.
// Depends on fgcm_pkg.
`default_nettype none
module fgcm_back import fgcm_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire logic [SAMPLE_BITS-1:0] q_left,
  input  wire logic [SAMPLE_BITS-1:0] q_right,
  input  wire logic [GAIN_W-1:0]      q_gain,
  input  wire fgcm_ctl_t              q_ctl,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_BITS-1:0]      out_left,
  output logic [SAMPLE_BITS-1:0]      out_right,
  output logic [GAIN_W-1:0]           out_gain,
  output logic                        out_done
);

  localparam int S = SAMPLE_BITS;
  localparam int P = SAMPLE_BITS + GAIN_W + 1;
  localparam logic signed [P-1:0] RND  = P'((64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1);
  localparam logic signed [P-1:0] SMAX = P'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [P-1:0] SMIN = -SMAX - P'(1);

  // product stage
  logic                a_valid_r;
  logic signed [P-1:0] a_pl_r, a_pr_r;
  fgcm_ctl_t           a_ctl_r;
  // output stage
  logic                o_valid_r;
  logic [S-1:0]        o_left_r, o_right_r;
  logic [GAIN_W-1:0]   o_gain_r;
  logic                o_done_r;

  logic                o_adv, a_adv;
  logic signed [P-1:0] sl_ext, sr_ext, g_ext;
  logic signed [S-1:0] l_sat, r_sat, avg, mix_l, mix_r;
  logic signed [S:0]   sum, sum_rnd;

  function automatic logic signed [S-1:0] sat_shift(input logic signed [P-1:0] p);
    logic signed [P-1:0] q;
    // bias negatives so the arithmetic shift truncates toward zero
    q = p + (p[P-1] ? RND : P'(0));
    q = q >>> GAIN_FRAC_BITS;
    if (q > SMAX) begin
      return S'(SMAX);
    end else if (q < SMIN) begin
      return S'(SMIN);
    end
    return q[S-1:0];
  endfunction

  assign o_adv   = !o_valid_r || out_ready;
  assign a_adv   = !a_valid_r || o_adv;
  assign q_ready = a_adv;

  // sample * gain, exact
  assign sl_ext = {{(GAIN_W + 1){q_left[S-1]}}, q_left};
  assign sr_ext = {{(GAIN_W + 1){q_right[S-1]}}, q_right};
  assign g_ext  = {{(S + 1){1'b0}}, q_gain};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && q_valid) begin
      a_pl_r  <= sl_ext * g_ext;
      a_pr_r  <= sr_ext * g_ext;
      a_ctl_r <= q_ctl;
    end
  end

  // truncate toward zero, saturate, then remap channels
  assign l_sat   = sat_shift(a_pl_r);
  assign r_sat   = sat_shift(a_pr_r);
  assign sum     = {l_sat[S-1], l_sat} + {r_sat[S-1], r_sat};
  assign sum_rnd = (sum + {{S{1'b0}}, sum[S]}) >>> 1;
  assign avg     = sum_rnd[S-1:0];

  always_comb begin
    priority if (a_ctl_r.in_mono) begin
      mix_l = l_sat;
      mix_r = l_sat;
    end else if (a_ctl_r.out_mono) begin
      mix_l = avg;
      mix_r = avg;
    end else begin
      mix_l = l_sat;
      mix_r = r_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_adv) begin
      o_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && a_valid_r) begin
      o_left_r  <= mix_l;
      o_right_r <= mix_r;
      o_gain_r  <= a_ctl_r.gain_now;
      o_done_r  <= a_ctl_r.fade_done;
    end
  end

  assign out_valid = o_valid_r;
  assign out_left  = o_left_r;
  assign out_right = o_right_r;
  assign out_gain  = o_gain_r;
  assign out_done  = o_done_r;

endmodule
`default_nettype wire
